// ===== rtl/dfd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfd_pkg
// shared constants and types of the deauthentication flood detector
// ----------------------------------------------------------------------------
`default_nettype none

package dfd_pkg;

  localparam int TRACKED_SOURCES = 16;
  localparam int IDX_W = (TRACKED_SOURCES > 1) ? $clog2(TRACKED_SOURCES) : 1;

  localparam logic [3:0]  MGMT_DISASSOC = 4'd10;
  localparam logic [3:0]  MGMT_DEAUTH   = 4'd12;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  localparam logic [15:0] THRESHOLD_RESET  = 16'd10;
  localparam logic [31:0] WINDOW_RESET     = 32'd1000;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_ALERT_THRESHOLD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = 8'd1;

  typedef struct packed {
    logic [3:0]  frame_subtype;
    logic [47:0] source_mac;
    logic [31:0] now_ms;
  } frame_t;

  typedef struct packed {
    logic        alert;
    logic        flood_kind;
    logic [15:0] frames_in_window;
    logic [47:0] alert_source;
  } result_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            data;
  } cfg_write_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [15:0] count;
    logic [31:0] window_start;
    logic        alerted;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/dfd_intf.sv =====
// ----------------------------------------------------------------------------
// dfd channel interfaces
// valid/ready channels for frames, results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface dfd_frame_if;
  import dfd_pkg::*;
  logic   valid;
  logic   ready;
  frame_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dfd_result_if;
  import dfd_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dfd_cfg_if;
  import dfd_pkg::*;
  logic       valid;
  logic       ready;
  cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/deauth_flood_detector.sv =====
// ----------------------------------------------------------------------------
// deauth_flood_detector
// per-source sliding-window rate detector for deauth/disassoc frames
// ----------------------------------------------------------------------------
// flow: a handled frame is registered, the slot memory is scanned in slot
//   order until its source is found or the last slot is compared, then the
//   chosen entry is updated and the result registered once the output is
//   free; an ignored subtype skips the scan. A frame is taken only in idle;
//   the scan reads one entry per cycle through the single read port
// reset: all slots free, alert_threshold 10, window_length_ms 1000
// ----------------------------------------------------------------------------
`default_nettype none

module deauth_flood_detector (
  input  wire logic     clk,
  input  wire logic     rst,
  dfd_frame_if.sink     frame_in,
  dfd_result_if.source  result_out,
  dfd_cfg_if.sink       cfg
);
  import dfd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACKED_SOURCES - 1);

  logic [1:0]  state;
  logic [15:0] alert_threshold;
  logic [31:0] window_length_ms;

  entry_t mem [TRACKED_SOURCES];
  entry_t rd_data;
  logic [TRACKED_SOURCES-1:0] slot_valid;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_vld;

  frame_t           frame_q;
  logic             ignore_q;
  logic             hit_q;
  entry_t           ent_q;
  logic [IDX_W-1:0] slot_q;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] victim_idx;
  logic [31:0]      victim_start;

  logic             free_found_next;
  logic [IDX_W-1:0] free_idx_next;
  logic [IDX_W-1:0] victim_idx_next;
  logic [31:0]      victim_start_next;
  logic             hit_now;

  entry_t      base;
  logic        expired;
  logic [15:0] count_base;
  logic        alerted_base;
  logic [15:0] count_new;
  logic        fire;
  entry_t      entry_new;
  logic        out_free;
  logic        frame_xfer;

  assign frame_in.ready = (state == ST_IDLE);
  assign frame_xfer     = frame_in.valid && frame_in.ready;
  assign cfg.ready      = 1'b1;
  assign out_free       = !result_out.valid || result_out.ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alert_threshold  <= THRESHOLD_RESET;
      window_length_ms <= WINDOW_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_ALERT_THRESHOLD: alert_threshold  <= cfg.data.data[15:0];
        REG_WINDOW_LENGTH:   window_length_ms <= cfg.data.data;
        default: ;
      endcase
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
    if (state == ST_UPDATE && out_free && !ignore_q) begin
      mem[slot_q] <= entry_new;
    end
  end

  // scan compare
  always_comb begin
    hit_now           = slot_valid[cmp_idx] && (rd_data.mac == frame_q.source_mac);
    free_found_next   = free_found;
    free_idx_next     = free_idx;
    victim_idx_next   = victim_idx;
    victim_start_next = victim_start;
    if (!free_found && !slot_valid[cmp_idx]) begin
      free_found_next = 1'b1;
      free_idx_next   = cmp_idx;
    end
    if (cmp_idx == '0 || rd_data.window_start < victim_start) begin
      victim_idx_next   = cmp_idx;
      victim_start_next = rd_data.window_start;
    end
  end

  // update of the selected entry
  always_comb begin
    if (hit_q) begin
      base = ent_q;
    end else begin
      base.mac          = frame_q.source_mac;
      base.count        = '0;
      base.window_start = frame_q.now_ms;
      base.alerted      = 1'b0;
    end
    expired      = (frame_q.now_ms - base.window_start) > window_length_ms;
    count_base   = expired ? 16'd0 : base.count;
    alerted_base = expired ? 1'b0 : base.alerted;
    count_new    = (count_base == COUNT_MAX) ? count_base : count_base + 16'd1;
    fire         = (count_new >= alert_threshold) && !alerted_base;
    entry_new.mac          = base.mac;
    entry_new.count        = count_new;
    entry_new.window_start = expired ? frame_q.now_ms : base.window_start;
    entry_new.alerted      = alerted_base || fire;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      slot_valid        <= '0;
      result_out.valid  <= 1'b0;
      cmp_vld           <= 1'b0;
      rd_idx            <= '0;
    end else begin
      if (state == ST_UPDATE && out_free) begin
        result_out.valid <= 1'b1;
      end else if (result_out.valid && result_out.ready) begin
        result_out.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (frame_xfer) begin
            frame_q    <= frame_in.data;
            ignore_q   <= (frame_in.data.frame_subtype != MGMT_DEAUTH) &&
                          (frame_in.data.frame_subtype != MGMT_DISASSOC);
            rd_idx     <= '0;
            cmp_vld    <= 1'b0;
            free_found <= 1'b0;
            if ((frame_in.data.frame_subtype != MGMT_DEAUTH) &&
                (frame_in.data.frame_subtype != MGMT_DISASSOC)) begin
              state <= ST_UPDATE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_idx  <= (rd_idx == LAST_IDX) ? rd_idx : rd_idx + 1'b1;
          cmp_idx <= rd_idx;
          cmp_vld <= 1'b1;
          if (cmp_vld) begin
            free_found   <= free_found_next;
            free_idx     <= free_idx_next;
            victim_idx   <= victim_idx_next;
            victim_start <= victim_start_next;
            if (hit_now) begin
              hit_q  <= 1'b1;
              ent_q  <= rd_data;
              slot_q <= cmp_idx;
              state  <= ST_UPDATE;
            end else if (cmp_idx == LAST_IDX) begin
              hit_q  <= 1'b0;
              slot_q <= free_found_next ? free_idx_next : victim_idx_next;
              state  <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            if (ignore_q) begin
              result_out.data <= '0;
            end else begin
              slot_valid[slot_q]                <= 1'b1;
              result_out.data.alert            <= fire;
              result_out.data.flood_kind       <= (frame_q.frame_subtype == MGMT_DISASSOC);
              result_out.data.frames_in_window <= count_new;
              result_out.data.alert_source     <= entry_new.mac;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/deauth_flood_detector_test.sv =====
// ----------------------------------------------------------------------------
// deauth_flood_detector_test
// self-checking bench for the per-source flood detector: frames go in over a
// valid/ready channel, a local model of the source table predicts every
// result, and a monitor compares each result transfer field by field
// ----------------------------------------------------------------------------
`default_nettype none

module deauth_flood_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dfd_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_REPORTS  = 10;
  localparam int POOL_DEPTH   = 24;

  localparam logic [3:0] SUBTYPE_ASSOC_REQ = 4'd0;
  localparam logic [3:0] SUBTYPE_AUTH      = 4'd11;
  localparam logic [3:0] SUBTYPE_ACTION    = 4'd13;
  localparam logic [3:0] SUBTYPE_RESERVED  = 4'd15;

  localparam logic [47:0] MAC_A      = 48'h02_00_5E_10_00_01;
  localparam logic [47:0] MAC_ZERO   = 48'h0;
  localparam logic [47:0] MAC_ONES   = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] EVICT_BASE = 48'h0A_0B_0C_00_00_00;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dfd_frame_if  frame_ch ();
  dfd_result_if result_ch ();
  dfd_cfg_if    cfg_ch ();

  deauth_flood_detector u_top (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_ch),
    .result_out (result_ch),
    .cfg        (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // local copy of the source table and the registers
  bit          trk_valid   [TRACKED_SOURCES];
  bit [47:0]   trk_mac     [TRACKED_SOURCES];
  bit [15:0]   trk_count   [TRACKED_SOURCES];
  bit [31:0]   trk_start   [TRACKED_SOURCES];
  bit          trk_alerted [TRACKED_SOURCES];
  logic [15:0] thr_cfg = THRESHOLD_RESET;
  logic [31:0] win_cfg = WINDOW_RESET;

  result_t     pending_verdicts [$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [31:0] clock_ms = 32'd0;
  logic [47:0] mac_pool [POOL_DEPTH];

  function automatic result_t flood_verdict(input frame_t f);
    result_t     r;
    int          hit;
    int          free_slot;
    int          victim;
    logic [31:0] elapsed;
    r = '0;
    if (f.frame_subtype != MGMT_DEAUTH && f.frame_subtype != MGMT_DISASSOC)
      return r;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < TRACKED_SOURCES; i++) begin
      if (hit < 0 && trk_valid[i] && trk_mac[i] == f.source_mac)
        hit = i;
      if (!trk_valid[i] && free_slot < 0)
        free_slot = i;
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        victim = 0;
        for (int i = 1; i < TRACKED_SOURCES; i++)
          if (trk_start[i] < trk_start[victim])
            victim = i;
        free_slot = victim;
      end
      hit = free_slot;
      trk_valid[hit]   = 1'b1;
      trk_mac[hit]     = f.source_mac;
      trk_start[hit]   = f.now_ms;
      trk_count[hit]   = '0;
      trk_alerted[hit] = 1'b0;
    end
    elapsed = f.now_ms - trk_start[hit];
    if (elapsed > win_cfg) begin
      trk_start[hit]   = f.now_ms;
      trk_count[hit]   = '0;
      trk_alerted[hit] = 1'b0;
    end
    if (trk_count[hit] != COUNT_MAX)
      trk_count[hit] = trk_count[hit] + 16'd1;
    if (trk_count[hit] >= thr_cfg && !trk_alerted[hit]) begin
      trk_alerted[hit] = 1'b1;
      r.alert = 1'b1;
    end
    r.flood_kind       = (f.frame_subtype == MGMT_DISASSOC);
    r.frames_in_window = trk_count[hit];
    r.alert_source     = trk_mac[hit];
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [63:0] exp,
                             input logic [63:0] act);
    if (exp !== act) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %0h actual %0h", fname, exp, act);
    end
  endtask

  // result monitor
  initial begin
    result_t exp;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result transfer with nothing pending: %0h", result_ch.data);
        end else begin
          exp = pending_verdicts.pop_front();
          check_field("alert", exp.alert, result_ch.data.alert);
          check_field("flood_kind", exp.flood_kind, result_ch.data.flood_kind);
          check_field("frames_in_window", exp.frames_in_window,
                      result_ch.data.frames_in_window);
          check_field("alert_source", exp.alert_source, result_ch.data.alert_source);
        end
      end
    end
  end

  // result receiver
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        result_ch.ready <= (!idle_on || $urandom_range(0, 99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_frame(input frame_t f);
    if (idle_on && $urandom_range(0, 99) < 10) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.data  <= f;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    pending_verdicts.push_back(flood_verdict(f));
  endtask

  task automatic wait_quiet();
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cfg_write_t'{idx, val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_ALERT_THRESHOLD)
      thr_cfg = val[15:0];
    else if (idx == REG_WINDOW_LENGTH)
      win_cfg = val;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_detector(input logic [15:0] thr, input logic [31:0] win);
    wait_quiet();
    write_reg(REG_ALERT_THRESHOLD, {16'($urandom), thr});
    write_reg(REG_WINDOW_LENGTH, win);
  endtask

  function automatic logic [47:0] rand_mac();
    logic [31:0] hi;
    hi = $urandom;
    return {hi[15:0], 32'($urandom)};
  endfunction

  function automatic logic [31:0] next_now();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      clock_ms = clock_ms + 32'($urandom_range(0, 50));
    else if (pick < 92)
      clock_ms = clock_ms + 32'($urandom_range(0, 3000));
    else
      clock_ms = $urandom;
    return clock_ms;
  endfunction

  task automatic test_reset_defaults();
    idle_on = 1'b1;
    for (int i = 0; i < 10; i++)
      send_frame(frame_t'{MGMT_DEAUTH, MAC_A, 32'(100 + i)});
    send_frame(frame_t'{MGMT_DISASSOC, MAC_A, 32'd1100});
    send_frame(frame_t'{MGMT_DEAUTH, MAC_A, 32'd1101});
  endtask

  task automatic test_long_burst();
    set_detector(16'd20, 32'hFFFF_FFFF);
    idle_on = 1'b0;
    for (int i = 0; i < 24; i++)
      send_frame(frame_t'{$urandom_range(0, 1) ? MGMT_DEAUTH : MGMT_DISASSOC,
                          MAC_A, $urandom});
    idle_on = 1'b1;
  endtask

  task automatic test_ignored_subtypes();
    send_frame(frame_t'{SUBTYPE_ASSOC_REQ, MAC_ONES, 32'd0});
    send_frame(frame_t'{SUBTYPE_AUTH, rand_mac(), $urandom});
    send_frame(frame_t'{SUBTYPE_ACTION, MAC_ZERO, $urandom});
    send_frame(frame_t'{SUBTYPE_RESERVED, MAC_A, 32'hFFFF_FFFF});
  endtask

  task automatic test_field_extremes();
    set_detector(16'd1, 32'd0);
    send_frame(frame_t'{MGMT_DEAUTH, MAC_ZERO, 32'd0});
    send_frame(frame_t'{MGMT_DEAUTH, MAC_ZERO, 32'd0});
    send_frame(frame_t'{MGMT_DISASSOC, MAC_ZERO, 32'd1});
    send_frame(frame_t'{MGMT_DISASSOC, MAC_ONES, 32'hFFFF_FFFF});
    send_frame(frame_t'{MGMT_DEAUTH, MAC_ONES, 32'd0});
    wait_quiet();
    write_reg(REG_UNUSED_LOW, $urandom);
    write_reg(REG_UNUSED_HIGH, 32'hFFFF_FFFF);
    send_frame(frame_t'{MGMT_DEAUTH, MAC_ONES, 32'd0});
    set_detector(16'd0, 32'd10);
    send_frame(frame_t'{MGMT_DEAUTH, MAC_ZERO, 32'd2});
    send_frame(frame_t'{MGMT_DEAUTH, MAC_ZERO, 32'd40});
  endtask

  task automatic test_eviction_order();
    set_detector(16'd100, 32'hFFFF_FFFF);
    for (int i = 0; i < TRACKED_SOURCES; i++)
      send_frame(frame_t'{MGMT_DEAUTH, EVICT_BASE + 48'(i),
                          (i < 4) ? 32'd7 : 32'hFFFF_FF00 + 32'(i)});
    for (int i = 0; i < 3; i++)
      send_frame(frame_t'{MGMT_DISASSOC, EVICT_BASE + 48'(64 + i), 32'(20 + i)});
    send_frame(frame_t'{MGMT_DEAUTH, EVICT_BASE, 32'd30});
  endtask

  task automatic test_result_backpressure();
    set_detector(16'd6, 32'd5000);
    idle_on = 1'b0;
    hold_req = 1'b1;
    @(posedge clk);
    for (int i = 0; i < 20; i++)
      send_frame(frame_t'{MGMT_DEAUTH, EVICT_BASE + 48'(i % 4), 32'(1000 + i)});
    wait_quiet();
    idle_on = 1'b1;
  endtask

  task automatic run_phase(input logic [15:0] thr, input logic [31:0] win,
                           input int pool_n, input bit idle);
    frame_t f;
    int     handled;
    set_detector(thr, win);
    idle_on = idle;
    handled = 0;
    while (handled < 38) begin
      if ($urandom_range(0, 99) < 88)
        f.frame_subtype = $urandom_range(0, 1) ? MGMT_DEAUTH : MGMT_DISASSOC;
      else
        f.frame_subtype = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 85)
        f.source_mac = mac_pool[$urandom_range(0, pool_n - 1)];
      else
        f.source_mac = rand_mac();
      f.now_ms = next_now();
      send_frame(f);
      if (f.frame_subtype == MGMT_DEAUTH || f.frame_subtype == MGMT_DISASSOC)
        handled++;
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    mac_pool[0] = MAC_ZERO;
    mac_pool[1] = MAC_ONES;
    for (int i = 2; i < POOL_DEPTH; i++)
      mac_pool[i] = rand_mac();
    clock_ms = $urandom;
    run_phase(16'd3, 32'd100, 6, 1'b1);
    run_phase(16'd1, 32'd0, 24, 1'b1);
    run_phase(16'd0, 32'd50, 12, 1'b1);
    run_phase(16'hFFFF, 32'hFFFF_FFFF, 8, 1'b0);
    run_phase(16'd5, 32'd2000, 24, 1'b1);
    run_phase(16'($urandom_range(1, 20)), 32'($urandom_range(0, 5000)), 20, 1'b1);
    run_phase(16'($urandom), 32'($urandom), 24, 1'b1);
    run_phase(16'd4, 32'd300, 4, 1'b1);
  endtask

  initial begin
    frame_ch.valid <= 1'b0;
    frame_ch.data  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_long_burst();
    test_ignored_subtypes();
    test_field_extremes();
    test_eviction_order();
    test_result_backpressure();
    test_random_traffic();
    wait_quiet();
    mismatches += pending_verdicts.size();
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
